/* rtl/gbs_pkg.sv */
package gbs_pkg;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_LEARN,
    KIND_MODEL,
    KIND_DETECT
  } item_kind_t;

  localparam int PIXEL_W = 8;
  localparam int SUM_W = 16;
  localparam int SQ_W = 24;
  localparam int WEIGHT_W = 16;
  localparam int LEARN_W = 9;
  localparam int ACTIVE_W = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_LEARN_FRAMES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VARIANCE_WEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_PIXELS = 2'd2;

  localparam logic [LEARN_W-1:0] LEARN_FRAMES_RST = 9'd200;
  localparam logic [WEIGHT_W-1:0] VARIANCE_WEIGHT_RST = 16'd256;
  localparam logic [ACTIVE_W-1:0] ACTIVE_PIXELS_RST = 20'd307200;

  localparam logic [PIXEL_W-1:0] MASK_FG = 8'd255;
  localparam logic [PIXEL_W-1:0] MASK_BG = 8'd0;
  localparam logic [PIXEL_W-1:0] MEAN_MAX = 8'd255;
  localparam logic [SQ_W-1:0] DEV_MAX = 24'hFFFFFF;

endpackage

/* rtl/gaussian_background_subtractor_core.sv */
// Channel  | Handshake              | Payload
// input    | in_valid / in_stall    | in_pixel
// result   | out_valid / out_stall  | out_mask, out_pixel_index, out_frame_end
// config   | cfg_we                 | cfg_index, cfg_data
//
// One pixel enters per cycle while in_stall is low; its result is offered on the output
// once the item has passed the thirteen-stage pipeline, whose divider for the mean
// takes eight of the stages.
// The input stalls while an item of the same raster position that still writes
// the pixel memories is in flight, so frames shorter than the pipeline slow down.
// Reset clears the counters, the pipeline valid bits and the output stage.
// The stores are undefined after reset and are written before they are read.
// A stall on the result side fills a skid register, after which the input stalls.
module gaussian_background_subtractor_core #(
  parameter int MAX_PIXELS = 524288,
  parameter int MAX_LEARN_FRAMES = 256
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [gbs_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  logic [gbs_pkg::CFG_DATA_W-1:0]           cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [gbs_pkg::PIXEL_W-1:0]              in_pixel,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [gbs_pkg::PIXEL_W-1:0]              out_mask,
  output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] out_pixel_index,
  output logic                                     out_frame_end
);
  import gbs_pkg::*;

  localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int PCW = $clog2(MAX_PIXELS + 1);
  localparam int NW = $clog2(MAX_LEARN_FRAMES + 1);
  localparam int FW = $clog2(MAX_LEARN_FRAMES + 2);
  localparam int ACC_W = WEIGHT_W + SQ_W;
  localparam int RHS_W = PIXEL_W + 1 + NW;
  localparam int NMM_W = NW + 2 * PIXEL_W;
  localparam int MS_W = PIXEL_W + SUM_W;
  localparam int D_W = 40;
  localparam int STAGES = 13;
  localparam int ST_LOAD = 1;
  localparam int ST_RHS = 2;
  localparam int ST_CMP = 3;
  localparam int ST_DIV = 2;
  localparam int QUO_W = 8;
  localparam int ST_SQ = ST_DIV + QUO_W;
  localparam int ST_NMM = ST_SQ + 1;
  localparam int ST_DEV = ST_NMM + 1;
  localparam int SUM_MEM_W = SUM_W + SQ_W;
  localparam int MDL_MEM_W = PIXEL_W + SQ_W;

  typedef struct packed {
    logic                 valid;
    item_kind_t           kind;
    logic [PW-1:0]        pos;
    logic                 last;
    logic [PIXEL_W-1:0]   x;
    logic [SUM_W-1:0]     s;
    logic [SQ_W-1:0]      sq;
    logic [PIXEL_W-1:0]   mean;
    logic [SQ_W-1:0]      dev;
    logic                 sat;
    logic [SUM_W-1:0]     rem;
    logic [QUO_W-1:0]     quo;
    logic [ACC_W-1:0]     acc;
    logic [PIXEL_W-1:0]   dif;
    logic [RHS_W-1:0]     rhs;
    logic                 fg;
    logic [2*PIXEL_W-1:0] mm;
    logic [MS_W-1:0]      ms;
    logic [NMM_W-1:0]     nmm;
  } stage_t;

  logic [LEARN_W-1:0]   learn_frames_r;
  logic [WEIGHT_W-1:0]  variance_weight_r;
  logic [ACTIVE_W-1:0]  active_pixels_r;
  logic [NW-1:0]        learn_n;
  logic [PCW-1:0]       frame_p;
  logic [FW-1:0]        frame_count_r;
  logic [FW-1:0]        frame_count_nxt;
  logic [PW-1:0]        pos_r;
  logic [PW-1:0]        pos_nxt;
  logic                 last_in;
  item_kind_t           kind_in;
  logic                 en;
  logic                 hazard;
  logic                 accept;
  stage_t               st_r [STAGES];
  stage_t               st_nxt [STAGES];
  logic [SUM_MEM_W-1:0] sum_mem [MAX_PIXELS];
  logic [MDL_MEM_W-1:0] mdl_mem [MAX_PIXELS];
  logic [SUM_MEM_W-1:0] rd_sum_r;
  logic [MDL_MEM_W-1:0] rd_mdl_r;
  logic                 res_v;
  logic [PIXEL_W-1:0]   res_mask;
  logic                 out_valid_r;
  logic [PIXEL_W-1:0]   out_mask_r;
  logic [PW-1:0]        out_index_r;
  logic                 out_end_r;
  logic                 skid_valid_r;
  logic [PIXEL_W-1:0]   skid_mask_r;
  logic [PW-1:0]        skid_index_r;
  logic                 skid_end_r;
  logic                 take;
  logic [D_W-1:0]       dsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_frames_r <= LEARN_FRAMES_RST;
      variance_weight_r <= VARIANCE_WEIGHT_RST;
      active_pixels_r <= ACTIVE_PIXELS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEARN_FRAMES: learn_frames_r <= cfg_data[LEARN_W-1:0];
        CFG_VARIANCE_WEIGHT: variance_weight_r <= cfg_data[WEIGHT_W-1:0];
        CFG_ACTIVE_PIXELS: active_pixels_r <= cfg_data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (learn_frames_r == '0) begin
      learn_n = NW'(1);
    end else if (32'(learn_frames_r) > MAX_LEARN_FRAMES) begin
      learn_n = NW'(MAX_LEARN_FRAMES);
    end else begin
      learn_n = NW'(learn_frames_r);
    end
    if (active_pixels_r == '0) begin
      frame_p = PCW'(1);
    end else if (32'(active_pixels_r) > MAX_PIXELS) begin
      frame_p = PCW'(MAX_PIXELS);
    end else begin
      frame_p = PCW'(active_pixels_r);
    end
  end

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < STAGES; k++) begin
      if (st_r[k].valid && st_r[k].kind != KIND_DETECT && st_r[k].pos == pos_r) begin
        hazard = 1'b1;
      end
    end
  end

  assign en = !skid_valid_r;
  assign in_stall = skid_valid_r || hazard;
  assign accept = in_valid && !in_stall;
  assign last_in = (32'(pos_r) + 32'd1) >= 32'(frame_p);

  always_comb begin
    if (32'(frame_count_r) < 32'(learn_n)) begin
      kind_in = (frame_count_r == '0) ? KIND_FIRST : KIND_LEARN;
    end else if (32'(frame_count_r) == 32'(learn_n)) begin
      kind_in = KIND_MODEL;
    end else begin
      kind_in = KIND_DETECT;
    end
    frame_count_nxt = frame_count_r;
    pos_nxt = pos_r;
    if (accept) begin
      if (last_in) begin
        pos_nxt = '0;
        if (32'(frame_count_r) <= 32'(learn_n)) begin
          frame_count_nxt = frame_count_r + FW'(1);
        end else begin
          frame_count_nxt = FW'(learn_n) + FW'(1);
        end
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      pos_r <= '0;
    end else begin
      frame_count_r <= frame_count_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    st_nxt[0] = '0;
    st_nxt[0].valid = accept;
    st_nxt[0].kind = kind_in;
    st_nxt[0].pos = pos_r;
    st_nxt[0].last = last_in;
    st_nxt[0].x = in_pixel;
    for (int k = 1; k < STAGES; k++) begin
      st_nxt[k] = st_r[k-1];
    end

    st_nxt[ST_LOAD].s = rd_sum_r[SUM_MEM_W-1:SQ_W];
    st_nxt[ST_LOAD].sq = rd_sum_r[SQ_W-1:0];
    st_nxt[ST_LOAD].mean = rd_mdl_r[MDL_MEM_W-1:SQ_W];
    st_nxt[ST_LOAD].dev = rd_mdl_r[SQ_W-1:0];
    if (st_r[0].kind == KIND_FIRST) begin
      st_nxt[ST_LOAD].s = SUM_W'(st_r[0].x);
      st_nxt[ST_LOAD].sq = SQ_W'(st_r[0].x) * SQ_W'(st_r[0].x);
    end else if (st_r[0].kind == KIND_LEARN) begin
      st_nxt[ST_LOAD].s = rd_sum_r[SUM_MEM_W-1:SQ_W] + SUM_W'(st_r[0].x);
      st_nxt[ST_LOAD].sq = rd_sum_r[SQ_W-1:0] + SQ_W'(st_r[0].x) * SQ_W'(st_r[0].x);
    end
    st_nxt[ST_LOAD].sat = 32'(rd_sum_r[SUM_MEM_W-1:SQ_W+8]) >= 32'(learn_n);
    st_nxt[ST_LOAD].rem = rd_sum_r[SUM_MEM_W-1:SQ_W];
    st_nxt[ST_LOAD].quo = '0;
    st_nxt[ST_LOAD].acc = ACC_W'(variance_weight_r) * ACC_W'(rd_mdl_r[SQ_W-1:0]);
    st_nxt[ST_LOAD].dif = (st_r[0].x > rd_mdl_r[MDL_MEM_W-1:SQ_W]) ?
                          st_r[0].x - rd_mdl_r[MDL_MEM_W-1:SQ_W] :
                          rd_mdl_r[MDL_MEM_W-1:SQ_W] - st_r[0].x;

    st_nxt[ST_RHS].rhs = RHS_W'(RHS_W'(st_r[ST_RHS-1].dif) * RHS_W'(learn_n));
    st_nxt[ST_CMP].fg = 64'(st_r[ST_CMP-1].acc) < (64'(st_r[ST_CMP-1].rhs) << 8);

    for (int b = 0; b < QUO_W; b++) begin
      if (32'(st_r[ST_DIV+b-1].rem) >= (32'(learn_n) << (QUO_W - 1 - b))) begin
        st_nxt[ST_DIV+b].rem = SUM_W'(32'(st_r[ST_DIV+b-1].rem) -
                                      (32'(learn_n) << (QUO_W - 1 - b)));
        st_nxt[ST_DIV+b].quo[QUO_W-1-b] = 1'b1;
      end
    end

    st_nxt[ST_SQ].mean = st_r[ST_SQ-1].sat ? MEAN_MAX : st_r[ST_SQ-1].quo;
    st_nxt[ST_SQ].mm = (2*PIXEL_W)'(st_nxt[ST_SQ].mean) * (2*PIXEL_W)'(st_nxt[ST_SQ].mean);
    st_nxt[ST_SQ].ms = MS_W'(st_nxt[ST_SQ].mean) * MS_W'(st_r[ST_SQ-1].s);

    st_nxt[ST_NMM].nmm = NMM_W'(learn_n) * NMM_W'(st_r[ST_NMM-1].mm);

    dsum = D_W'(st_r[ST_DEV-1].sq) + D_W'(st_r[ST_DEV-1].nmm) -
           (D_W'(st_r[ST_DEV-1].ms) << 1);
    if (dsum[D_W-1]) begin
      st_nxt[ST_DEV].dev = '0;
    end else if (dsum > D_W'(DEV_MAX)) begin
      st_nxt[ST_DEV].dev = DEV_MAX;
    end else begin
      st_nxt[ST_DEV].dev = dsum[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) begin
        st_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_sum_r <= sum_mem[pos_r];
      rd_mdl_r <= mdl_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (en && st_r[STAGES-1].valid) begin
      if (st_r[STAGES-1].kind == KIND_FIRST || st_r[STAGES-1].kind == KIND_LEARN) begin
        sum_mem[st_r[STAGES-1].pos] <= {st_r[STAGES-1].s, st_r[STAGES-1].sq};
      end
      if (st_r[STAGES-1].kind == KIND_MODEL) begin
        mdl_mem[st_r[STAGES-1].pos] <= {st_r[STAGES-1].mean, st_r[STAGES-1].dev};
      end
    end
  end

  assign res_v = en && st_r[STAGES-1].valid && st_r[STAGES-1].kind == KIND_DETECT;
  assign res_mask = st_r[STAGES-1].fg ? MASK_FG : MASK_BG;
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take || !out_valid_r) begin
        out_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (take || !out_valid_r) begin
      out_valid_r <= res_v;
    end else if (res_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take || !out_valid_r) begin
        out_mask_r <= skid_mask_r;
        out_index_r <= skid_index_r;
        out_end_r <= skid_end_r;
      end
    end else if (take || !out_valid_r) begin
      out_mask_r <= res_mask;
      out_index_r <= st_r[STAGES-1].pos;
      out_end_r <= st_r[STAGES-1].last;
    end else begin
      skid_mask_r <= res_mask;
      skid_index_r <= st_r[STAGES-1].pos;
      skid_end_r <= st_r[STAGES-1].last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mask = out_mask_r;
  assign out_pixel_index = out_index_r;
  assign out_frame_end = out_end_r;

  // The skid register only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while the output stage is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid register filled without a stalled result");

  // No item is accepted while a write to its raster position is still in flight.
  a_no_hazard_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !(st_r[STAGES-1].valid && $past(hazard)))
    else $error("item accepted over a pending write to the same position");

endmodule
